// ===== hw/rtl/cb_pkg.sv =====
// Shared constants and types of the comment blanker.
package cb_pkg;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// One queue entry: the one or two output bytes that a single input beat produces.
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic       two;
		logic       last;
	} cb_entry_t;

	// Head of the queue as seen by the output side.
	typedef struct packed {
		logic      avail;
		cb_entry_t entry;
	} cb_head_t;

endpackage

// ===== hw/rtl/cb_in_if.sv =====
// Input byte channel of the comment blanker.
interface cb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== hw/rtl/cb_out_if.sv =====
// Output byte channel of the comment blanker.
interface cb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== hw/rtl/cb_lexer.sv =====
// Front end: lexer state machine that turns each input beat into a queue entry, or none while it holds a byte back.
module cb_lexer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              q_full,
	output logic              push,
	output cb_pkg::cb_entry_t push_entry
);
	import cb_pkg::*;

	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_STR     = 3'd1,
		MODE_STR_ESC = 3'd2,
		MODE_CHR     = 3'd3,
		MODE_CHR_ESC = 3'd4,
		MODE_LINE    = 3'd5,
		MODE_BLOCK   = 3'd6
	} lex_mode_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] ch;
		lex_mode_t  mode;
		logic       hold;
	} plain_res_t;

	lex_mode_t  mode_q;
	logic       held_q;
	lex_mode_t  mode_d;
	logic       held_d;
	logic       accept;
	plain_res_t pr;
	lex_mode_t  plain_mode;
	logic       emit0;
	logic [7:0] ch0;
	logic       emit1;
	logic [7:0] ch1;

	// Handling of one byte on its own, without regard to a byte held back.
	function automatic plain_res_t plain_step(lex_mode_t m, logic [7:0] b, logic lst);
		plain_res_t r;
		r.emit = 1'b1;
		r.ch   = b;
		r.mode = m;
		r.hold = 1'b0;
		case (m)
			MODE_STR: begin
				if (b == CH_BSLASH) r.mode = MODE_STR_ESC;
				else if (b == CH_DQUOTE) r.mode = MODE_NORMAL;
			end
			MODE_STR_ESC: r.mode = MODE_STR;
			MODE_CHR: begin
				if (b == CH_BSLASH) r.mode = MODE_CHR_ESC;
				else if (b == CH_SQUOTE) r.mode = MODE_NORMAL;
			end
			MODE_CHR_ESC: r.mode = MODE_CHR;
			MODE_LINE: begin
				if (b == CH_NL) r.mode = MODE_NORMAL;
				else r.ch = CH_SPACE;
			end
			MODE_BLOCK: begin
				if (b == CH_STAR) begin
					r.ch = CH_SPACE;
					if (!lst) begin
						r.emit = 1'b0;
						r.hold = 1'b1;
					end
				end else if (b != CH_NL) begin
					r.ch = CH_SPACE;
				end
			end
			default: begin
				r.mode = MODE_NORMAL;
				if (b == CH_DQUOTE) r.mode = MODE_STR;
				else if (b == CH_SQUOTE) r.mode = MODE_CHR;
				else if (b == CH_SLASH && !lst) begin
					r.emit = 1'b0;
					r.hold = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// A held slash outside a block comment always returns the lexer to normal text.
	always_comb begin
		if (held_q && mode_q != MODE_BLOCK) plain_mode = MODE_NORMAL;
		else plain_mode = mode_q;
	end

	assign pr = plain_step(plain_mode, in_byte, in_last);

	always_comb begin
		emit0  = pr.emit;
		ch0    = pr.ch;
		emit1  = 1'b0;
		ch1    = CH_SPACE;
		mode_d = pr.mode;
		held_d = pr.hold;
		if (held_q) begin
			emit0 = 1'b1;
			if (mode_q == MODE_BLOCK) begin
				ch0 = CH_SPACE;
				if (in_byte == CH_SLASH) begin
					emit1  = 1'b1;
					mode_d = MODE_NORMAL;
					held_d = 1'b0;
				end else begin
					emit1 = pr.emit;
					ch1   = pr.ch;
				end
			end else begin
				if (in_byte == CH_SLASH || in_byte == CH_STAR) begin
					ch0    = CH_SPACE;
					emit1  = 1'b1;
					mode_d = (in_byte == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
					held_d = 1'b0;
				end else begin
					ch0   = CH_SLASH;
					emit1 = pr.emit;
					ch1   = pr.ch;
				end
			end
		end
		if (in_last) begin
			mode_d = MODE_NORMAL;
			held_d = 1'b0;
		end
	end

	assign push            = accept && emit0;
	assign push_entry.b0   = ch0;
	assign push_entry.b1   = ch1;
	assign push_entry.two  = emit1;
	assign push_entry.last = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			held_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			held_q <= held_d;
		end
	end

endmodule

// ===== hw/rtl/cb_queue.sv =====
// Small register queue of entries between the lexer and the output stage.
module cb_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cb_pkg::cb_entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output cb_pkg::cb_head_t  head
);
	import cb_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cb_entry_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign full       = (count_q == FULL_CNT);
	assign head.avail = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.avail;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !do_pop) count_q <= count_q + 1'b1;
			else if (!push && do_pop) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/cb_emitter.sv =====
// Back end: output register that hands out the bytes of each entry one beat at a time.
module cb_emitter (
	input  logic             clk,
	input  logic             arst_n,
	input  cb_pkg::cb_head_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             out_last
);
	import cb_pkg::*;

	cb_entry_t ent_q;
	logic      valid_q;
	logic      idx_q;
	logic      done;
	logic      load;

	// The entry is finished when its final byte leaves on this edge.
	assign done = valid_q && out_ready && (idx_q == ent_q.two);
	assign load = !valid_q || done;
	assign pop  = load && head.avail;

	assign out_valid = valid_q;
	assign out_byte  = idx_q ? ent_q.b1 : ent_q.b0;
	assign out_last  = ent_q.last && (idx_q == ent_q.two);

	always_ff @(posedge clk) begin
		if (pop) ent_q <= head.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else if (load) begin
			valid_q <= head.avail;
			idx_q   <= 1'b0;
		end else if (out_ready) begin
			idx_q <= 1'b1;
		end
	end

endmodule

// ===== hw/rtl/c_comment_blanker.sv =====
// Top level of the streaming C/C++ comment blanker.
//
// rx carries the source text, one byte per beat, with in_last on the final
// byte of a text. tx returns the text with every comment turned into spaces;
// newlines inside block comments are kept, and out_last marks the final byte.
// Each input beat yields zero, one or two output beats (a held slash or star
// is released together with the byte that follows it).
// The lexer takes one input beat per cycle while the queue has room. The
// output register sends one byte per cycle while tx is ready, and a beat
// that yields two bytes holds it until both have left; with tx ready the
// sustained rate is one input byte per cycle for ordinary text. An accepted
// byte passes through the queue into the output register before it is sent.
// While tx is stalled the queue fills, and once it holds QUEUE_DEPTH entries
// rx.ready drops until the output register takes the next entry from it.
// Reset empties the queue and returns the lexer to normal text with nothing
// held.
module c_comment_blanker #(
	parameter int QUEUE_DEPTH = 4
) (
	input logic      clk,
	input logic      arst_n,
	cb_in_if.sink    rx,
	cb_out_if.source tx
);
	import cb_pkg::*;

	logic      q_full;
	logic      push;
	cb_entry_t push_entry;
	logic      pop;
	cb_head_t  head;

	cb_lexer u_lexer (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (rx.valid),
		.in_ready   (rx.ready),
		.in_byte    (rx.in_byte),
		.in_last    (rx.in_last),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	cb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head)
	);

	cb_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (tx.valid),
		.out_ready (tx.ready),
		.out_byte  (tx.out_byte),
		.out_last  (tx.out_last)
	);

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the comment blanker: C-like texts checked beat by beat.
`timescale 1ns / 1ps

module testbench;
	import cb_pkg::*;

	localparam int TEXT_BEATS  = 1400;
	localparam int CYCLE_LIMIT = 300000;

	typedef enum logic [2:0] {
		LX_NORMAL,
		LX_STRING,
		LX_STR_ESC,
		LX_CHAR,
		LX_CHAR_ESC,
		LX_LINE_CMT,
		LX_BLOCK_CMT
	} lex_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} text_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	cb_in_if  rx_if ();
	cb_out_if tx_if ();

	c_comment_blanker uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_beat_t source_q[$];
	text_beat_t blanked_q[$];
	text_beat_t step_bytes[$];
	logic [7:0] text_buf[$];

	lex_mode_t  lex_mode = LX_NORMAL;
	bit         held     = 1'b0;
	int         beats_taken = 0;
	int         total_beats = 0;
	int         errors = 0;
	int         cycles = 0;

	// Predictor of the blanker, one input beat at a time.
	function automatic void emit(logic [7:0] b);
		step_bytes.push_back('{data: b, last: 1'b0});
	endfunction

	function automatic void lex_plain(logic [7:0] b, bit last);
		case (lex_mode)
			LX_STRING: begin
				emit(b);
				if (b == CH_BSLASH) lex_mode = LX_STR_ESC;
				else if (b == CH_DQUOTE) lex_mode = LX_NORMAL;
			end
			LX_STR_ESC: begin
				emit(b);
				lex_mode = LX_STRING;
			end
			LX_CHAR: begin
				emit(b);
				if (b == CH_BSLASH) lex_mode = LX_CHAR_ESC;
				else if (b == CH_SQUOTE) lex_mode = LX_NORMAL;
			end
			LX_CHAR_ESC: begin
				emit(b);
				lex_mode = LX_CHAR;
			end
			LX_LINE_CMT: begin
				if (b == CH_NL) begin
					emit(CH_NL);
					lex_mode = LX_NORMAL;
				end else begin
					emit(CH_SPACE);
				end
			end
			LX_BLOCK_CMT: begin
				if (b == CH_STAR) begin
					if (last) emit(CH_SPACE);
					else held = 1'b1;
				end else if (b == CH_NL) begin
					emit(CH_NL);
				end else begin
					emit(CH_SPACE);
				end
			end
			default: begin
				lex_mode = LX_NORMAL;
				if (b == CH_DQUOTE) begin
					emit(b);
					lex_mode = LX_STRING;
				end else if (b == CH_SQUOTE) begin
					emit(b);
					lex_mode = LX_CHAR;
				end else if (b == CH_SLASH) begin
					if (last) emit(CH_SLASH);
					else held = 1'b1;
				end else begin
					emit(b);
				end
			end
		endcase
	endfunction

	function automatic void predict_blanked(logic [7:0] b, bit last);
		step_bytes.delete();
		if (held) begin
			held = 1'b0;
			if (lex_mode == LX_BLOCK_CMT) begin
				if (b == CH_SLASH) begin
					emit(CH_SPACE);
					emit(CH_SPACE);
					lex_mode = LX_NORMAL;
				end else begin
					// The held star was not a closer, so it becomes a blank.
					emit(CH_SPACE);
					lex_plain(b, last);
				end
			end else begin
				lex_mode = LX_NORMAL;
				if (b == CH_SLASH) begin
					emit(CH_SPACE);
					emit(CH_SPACE);
					lex_mode = LX_LINE_CMT;
				end else if (b == CH_STAR) begin
					emit(CH_SPACE);
					emit(CH_SPACE);
					lex_mode = LX_BLOCK_CMT;
				end else begin
					emit(CH_SLASH);
					lex_plain(b, last);
				end
			end
		end else begin
			lex_plain(b, last);
		end
		if (last) begin
			if (step_bytes.size() != 0) step_bytes[$].last = 1'b1;
			lex_mode = LX_NORMAL;
			held = 1'b0;
		end
		foreach (step_bytes[i]) blanked_q.push_back(step_bytes[i]);
	endfunction

	// Text building.
	function automatic void put(logic [7:0] b);
		text_buf.push_back(b);
	endfunction

	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++) put(s[i]);
	endfunction

	function automatic void end_text();
		foreach (text_buf[i])
			source_q.push_back('{data: text_buf[i], last: (i == text_buf.size() - 1)});
		text_buf.delete();
	endfunction

	function automatic logic [7:0] pick_char();
		string lexical = "ab_ 9;\n/*\"'\\";
		if ($urandom_range(99) < 15) return 8'($urandom_range(255));
		return lexical[$urandom_range(lexical.len() - 1)];
	endfunction

	function automatic void gen_text();
		int n_tok;
		int kind;
		n_tok = $urandom_range(1, 10);
		repeat (n_tok) begin
			kind = $urandom_range(99);
			if (kind < 22) begin
				repeat ($urandom_range(1, 6)) put(pick_char());
			end else if (kind < 36) begin
				put(CH_DQUOTE);
				repeat ($urandom_range(0, 6)) begin
					if ($urandom_range(4) == 0) put(CH_BSLASH);
					put(pick_char());
				end
				if ($urandom_range(9) != 0) put(CH_DQUOTE);
			end else if (kind < 46) begin
				put(CH_SQUOTE);
				if ($urandom_range(2) == 0) put(CH_BSLASH);
				put(pick_char());
				if ($urandom_range(9) != 0) put(CH_SQUOTE);
			end else if (kind < 62) begin
				put(CH_SLASH);
				put(CH_SLASH);
				repeat ($urandom_range(0, 8)) put(pick_char());
				if ($urandom_range(6) != 0) put(CH_NL);
			end else if (kind < 80) begin
				put(CH_SLASH);
				put(CH_STAR);
				repeat ($urandom_range(0, 10)) put(pick_char());
				if ($urandom_range(3) == 0) put(CH_STAR);
				if ($urandom_range(6) != 0) begin
					put(CH_STAR);
					put(CH_SLASH);
				end
			end else if (kind < 90) begin
				put(CH_SLASH);
				put(pick_char());
			end else begin
				put(8'($urandom_range(255)));
			end
		end
		end_text();
	endfunction

	function automatic int idle_pct(bit sender);
		if (beats_taken < total_beats / 3) return sender ? 22 : 81;
		if (beats_taken < 2 * total_beats / 3) return sender ? 81 : 22;
		return 0;
	endfunction

	// Source side: offers the next pending beat, holding it until it is taken.
	always @(posedge clk) begin : drive_rx
		text_beat_t nxt;
		if (arst_n) begin
			if (rx_if.valid && rx_if.ready) begin
				predict_blanked(rx_if.in_byte, rx_if.in_last);
				beats_taken++;
			end
			if (!rx_if.valid || rx_if.ready) begin
				if (source_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
					nxt = source_q.pop_front();
					rx_if.valid   <= 1'b1;
					rx_if.in_byte <= nxt.data;
					rx_if.in_last <= nxt.last;
				end else begin
					rx_if.valid <= 1'b0;
				end
			end
		end
	end

	// Sink side: checks every beat against the oldest predicted byte.
	always @(posedge clk) begin : watch_tx
		text_beat_t want;
		if (arst_n) begin
			if (tx_if.valid && tx_if.ready) begin
				if (blanked_q.size() == 0) begin
					$error("out_byte: expected none, actual %h", tx_if.out_byte);
					errors++;
				end else begin
					want = blanked_q.pop_front();
					if (tx_if.out_byte !== want.data) begin
						$error("out_byte: expected %h, actual %h", want.data, tx_if.out_byte);
						errors++;
					end
					if (tx_if.out_last !== want.last) begin
						$error("out_last: expected %b, actual %b", want.last, tx_if.out_last);
						errors++;
					end
				end
			end
			tx_if.ready <= ($urandom_range(99) >= idle_pct(1'b0));
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$error("timeout with %0d bytes still expected", blanked_q.size());
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.in_byte = 8'h00;
		rx_if.in_last = 1'b0;
		tx_if.ready   = 1'b0;

		// Slash before a plain byte, then a line comment with a backslash before its newline.
		put_str("/b//\\\n");
		end_text();
		// Opener reuse, newline kept in a block comment, star star slash closer.
		put_str("/*/\n**/");
		end_text();
		// Escaped quote and a slash in a string, escaped quote in a char literal.
		put_str("\"\\\"/\"'\\''");
		end_text();
		// A lone slash on the last byte, and a star on the last byte of a block comment.
		put_str("/");
		end_text();
		put_str("/**");
		end_text();
		put(8'h00);
		put(8'hFF);
		end_text();
		while (source_q.size() < TEXT_BEATS) gen_text();
		total_beats = source_q.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (source_q.size() != 0 || rx_if.valid) @(posedge clk);
		while (blanked_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
